// File: hw/rtl/ray_box_slab_intersect_assert.svh
// assertion macros for the ray box slab intersect block
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// clocked assertion, disabled while reset is held
`define RBSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a stalled beat keeps its signal unchanged
`define RBSI_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  `RBSI_ASSERT(lbl, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

// File: hw/rtl/rbsi_pkg.sv
// shared constants and types for the ray box slab intersect block
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int AXES      = 3;

  // zero direction classification, taken at lane entry
  typedef struct packed {
    logic zero;
    logic in_slab;
    logic below;
  } zdir_t;

  // per lane status passed to the merge stage
  typedef struct packed {
    logic miss;
    logic ovf;
  } lane_flags_t;

endpackage

// File: hw/rtl/ray_box_slab_intersect.sv
// top level of the ray against axis-aligned box slab test
// usage
// - input channel: one beat carries a ray (origin, direction) and a box (lo, hi
//   corners), all signed fixed point with 16 fraction bits
// - output channel: one beat per input beat, hit, t_near, t_far and overflowed
// - three axis lanes run side by side, each with two pipelined dividers that
//   resolve one quotient bit per stage; a merge stage takes the max and min
// - the pipeline runs through an operand stage, COORD_BITS + 17 divider stages,
//   saturation, lane ordering, merge and output
// - throughput is one beat per cycle while the pipeline is not held, set by the
//   divider pipelines, which take a new pair of operands every cycle they advance
// - the output register is the last pipeline stage; when the receiver stalls on
//   a valid output beat the whole pipeline holds and in_ready_o drops, and it
//   rises again in the cycle the held beat is taken
// - reset clears the valid markers only, so no beat leaves until one arrives
module ray_box_slab_intersect #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] box_lo_x_i,
  input  logic signed [COORD_BITS-1:0] box_lo_y_i,
  input  logic signed [COORD_BITS-1:0] box_lo_z_i,
  input  logic signed [COORD_BITS-1:0] box_hi_x_i,
  input  logic signed [COORD_BITS-1:0] box_hi_y_i,
  input  logic signed [COORD_BITS-1:0] box_hi_z_i,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] origin_z_i,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] dir_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] t_near_o,
  output logic signed [COORD_BITS-1:0] t_far_o,
  output logic                         overflowed_o
);

  localparam int CB  = COORD_BITS;
  localparam int QB  = CB + 1 + rbsi_pkg::FRAC_BITS;
  // lane: operand, divider, saturation and ordering stages; merge two stages
  localparam int LAT = QB + 5;

  // pipeline advance: everything moves unless a finished beat is stuck
  logic en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // per axis operands
  logic signed [CB-1:0] lo  [rbsi_pkg::AXES];
  logic signed [CB-1:0] hi  [rbsi_pkg::AXES];
  logic signed [CB-1:0] org [rbsi_pkg::AXES];
  logic signed [CB-1:0] dir [rbsi_pkg::AXES];

  assign lo[0]  = box_lo_x_i;
  assign lo[1]  = box_lo_y_i;
  assign lo[2]  = box_lo_z_i;
  assign hi[0]  = box_hi_x_i;
  assign hi[1]  = box_hi_y_i;
  assign hi[2]  = box_hi_z_i;
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  logic signed [CB-1:0]  enter [rbsi_pkg::AXES];
  logic signed [CB-1:0]  leave [rbsi_pkg::AXES];
  rbsi_pkg::lane_flags_t flags [rbsi_pkg::AXES];

  for (genvar a = 0; a < rbsi_pkg::AXES; a++) begin : g_lane
    rbsi_lane #(.COORD_BITS(CB)) u_lane (
      .clk_i,
      .en_i    (en),
      .lo_i    (lo[a]),
      .hi_i    (hi[a]),
      .org_i   (org[a]),
      .dir_i   (dir[a]),
      .enter_o (enter[a]),
      .leave_o (leave[a]),
      .flags_o (flags[a])
    );
  end

  // merge holds the output register as its final stage
  rbsi_merge #(.COORD_BITS(CB)) u_merge (
    .clk_i,
    .en_i     (en),
    .enter_i  (enter),
    .leave_i  (leave),
    .flags_i  (flags),
    .hit_o,
    .t_near_o,
    .t_far_o,
    .ovf_o    (overflowed_o)
  );

endmodule

// File: hw/rtl/rbsi_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated result
module rbsi_div #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS:0]   num_i,
  input  logic signed [COORD_BITS-1:0] den_i,
  output logic signed [COORD_BITS-1:0] quo_o,
  output logic                         ovf_o
);

  localparam int CB = COORD_BITS;
  localparam int NB = CB + 1;
  localparam int FB = rbsi_pkg::FRAC_BITS;
  localparam int QB = NB + FB;
  localparam logic [QB-1:0] LIM_POS = QB'((65'd1 << (CB - 1)) - 65'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(65'd1 << (CB - 1));
  localparam logic signed [CB-1:0] VMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] VMIN = {1'b1, {(CB-1){1'b0}}};

  logic [QB-1:0] dvd_q [QB];
  logic [CB-1:0] rem_q [QB];
  logic [CB-1:0] ud_q  [QB];
  logic [QB-1:0] quo_q [QB+1];
  logic          neg_q [QB+1];

  logic [NB-1:0] un;
  logic [CB-1:0] ud;
  logic          neg;

  assign neg = num_i[NB-1] ^ den_i[CB-1];
  assign un  = num_i[NB-1] ? NB'(-num_i) : NB'(num_i);
  assign ud  = den_i[CB-1] ? CB'(-den_i) : CB'(den_i);

  // operand magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q[0] <= {un, {FB{1'b0}}};
      rem_q[0] <= '0;
      ud_q[0]  <= ud;
      quo_q[0] <= '0;
      neg_q[0] <= neg;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [CB:0] trial;
    logic [CB:0] diff;
    logic        ge;

    assign trial = {rem_q[s], dvd_q[s][QB-1]};
    assign diff  = trial - {1'b0, ud_q[s]};
    assign ge    = trial >= {1'b0, ud_q[s]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1] <= {quo_q[s][QB-2:0], ge};
        neg_q[s+1] <= neg_q[s];
      end
    end

    if (s < QB - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= ge ? diff[CB-1:0] : trial[CB-1:0];
          dvd_q[s+1] <= {dvd_q[s][QB-2:0], 1'b0};
          ud_q[s+1]  <= ud_q[s];
        end
      end
    end
  end

  // saturation and sign
  logic                  ovf;
  logic [CB-1:0]         mag;
  logic signed [CB-1:0]  res;

  assign ovf = quo_q[QB] > (neg_q[QB] ? LIM_NEG : LIM_POS);
  assign mag = quo_q[QB][CB-1:0];
  assign res = ovf ? (neg_q[QB] ? VMIN : VMAX)
                   : (neg_q[QB] ? CB'(-mag) : CB'(mag));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= res;
      ovf_o <= ovf;
    end
  end

endmodule

// File: hw/rtl/rbsi_lane.sv
// one axis lane: two slab divisions and the zero direction case
module rbsi_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] lo_i,
  input  logic signed [COORD_BITS-1:0] hi_i,
  input  logic signed [COORD_BITS-1:0] org_i,
  input  logic signed [COORD_BITS-1:0] dir_i,
  output logic signed [COORD_BITS-1:0] enter_o,
  output logic signed [COORD_BITS-1:0] leave_o,
  output rbsi_pkg::lane_flags_t        flags_o
);

  localparam int CB = COORD_BITS;
  localparam int QB = CB + 1 + rbsi_pkg::FRAC_BITS;
  localparam int LD = QB + 2;
  localparam logic signed [CB-1:0] VMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] VMIN = {1'b1, {(CB-1){1'b0}}};

  logic signed [CB:0] num_lo, num_hi;
  assign num_lo = {lo_i[CB-1], lo_i} - {org_i[CB-1], org_i};
  assign num_hi = {hi_i[CB-1], hi_i} - {org_i[CB-1], org_i};

  logic signed [CB-1:0] qa, qb;
  logic                 oa, ob;

  rbsi_div #(.COORD_BITS(CB)) u_div_lo (
    .clk_i, .en_i, .num_i(num_lo), .den_i(dir_i), .quo_o(qa), .ovf_o(oa)
  );
  rbsi_div #(.COORD_BITS(CB)) u_div_hi (
    .clk_i, .en_i, .num_i(num_hi), .den_i(dir_i), .quo_o(qb), .ovf_o(ob)
  );

  rbsi_pkg::zdir_t zin;
  rbsi_pkg::zdir_t zd_q [LD];

  assign zin.zero    = (dir_i == '0);
  assign zin.in_slab = (lo_i <= org_i) && (org_i <= hi_i);
  assign zin.below   = (org_i < lo_i);

  // zero direction flags ride alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zd_q[0] <= zin;
    end
  end
  for (genvar s = 1; s < LD; s++) begin : g_zd
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zd_q[s] <= zd_q[s-1];
      end
    end
  end

  rbsi_pkg::zdir_t z;
  assign z = zd_q[LD-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z.zero) begin
        flags_o.ovf <= 1'b0;
        if (z.in_slab) begin
          enter_o      <= VMIN;
          leave_o      <= VMAX;
          flags_o.miss <= 1'b0;
        end else begin
          enter_o      <= z.below ? VMAX : VMIN;
          leave_o      <= z.below ? VMAX : VMIN;
          flags_o.miss <= 1'b1;
        end
      end else begin
        enter_o      <= (qa < qb) ? qa : qb;
        leave_o      <= (qa < qb) ? qb : qa;
        flags_o.miss <= 1'b0;
        flags_o.ovf  <= oa | ob;
      end
    end
  end

endmodule

// File: hw/rtl/rbsi_merge.sv
// merge of the three lanes: latest entry, earliest exit, hit decision
module rbsi_merge #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] enter_i [rbsi_pkg::AXES],
  input  logic signed [COORD_BITS-1:0] leave_i [rbsi_pkg::AXES],
  input  rbsi_pkg::lane_flags_t        flags_i [rbsi_pkg::AXES],
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] t_near_o,
  output logic signed [COORD_BITS-1:0] t_far_o,
  output logic                         ovf_o
);

  logic signed [COORD_BITS-1:0] tn01, tf01, tn, tf;
  logic signed [COORD_BITS-1:0] tn_q, tf_q;
  logic                         miss_q, ovf_q;

  assign tn01 = (enter_i[1] > enter_i[0]) ? enter_i[1] : enter_i[0];
  assign tn   = (enter_i[2] > tn01) ? enter_i[2] : tn01;
  assign tf01 = (leave_i[1] < leave_i[0]) ? leave_i[1] : leave_i[0];
  assign tf   = (leave_i[2] < tf01) ? leave_i[2] : tf01;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tn_q   <= tn;
      tf_q   <= tf;
      miss_q <= flags_i[0].miss | flags_i[1].miss | flags_i[2].miss;
      ovf_q  <= flags_i[0].ovf | flags_i[1].ovf | flags_i[2].ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o    <= !miss_q && (tn_q <= tf_q);
      t_near_o <= tn_q;
      t_far_o  <= tf_q;
      ovf_o    <= ovf_q;
    end
  end

endmodule

// File: hw/rtl/rbsi_checker.sv
// port level checks for the ray box slab intersect block
`include "ray_box_slab_intersect_assert.svh"

module rbsi_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         hit_o,
  input logic signed [COORD_BITS-1:0] t_near_o,
  input logic signed [COORD_BITS-1:0] t_far_o
);

  `RBSI_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, t_near_o, "stalled beat changed")
  `RBSI_ASSERT(a_hit_order, out_valid_o && hit_o |-> t_near_o <= t_far_o, "hit with bad order")
  `RBSI_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i), "ready mismatch")

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_BITS(COORD_BITS)) u_rbsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .t_near_o    (t_near_o),
  .t_far_o     (t_far_o)
);

// File: tb/ray_box_slab_intersect_test.sv
// testbench for the ray against axis-aligned box slab test, self-checking by prediction
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;

  localparam int W = 32;

  // handy fixed point values, Q16.16
  localparam logic [W-1:0] MX  = 32'h7fff_ffff;
  localparam logic [W-1:0] MN  = 32'h8000_0000;
  localparam logic [W-1:0] ONE = 32'h0001_0000;
  localparam logic [W-1:0] NEG_ONE = 32'hffff_0000;
  localparam longint TPOS = 64'sd2147483647;
  localparam longint TNEG = -64'sd2147483648;

  // field order of a ray beat: box lo xyz, box hi xyz, origin xyz, direction xyz
  localparam int LO = 0, HI = 3, ORG = 6, DIR = 9;

  typedef struct packed {
    logic         hit;
    logic [W-1:0] t_near;
    logic [W-1:0] t_far;
    logic         ovf;
  } slab_res_t;

  typedef struct {
    logic [W-1:0] f [12];
    bit           fixed;   // result typed in below, not predicted
    slab_res_t    res;
  } ray_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [W-1:0] fld [12];
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic         hit_o;
  logic [W-1:0] t_near_o;
  logic [W-1:0] t_far_o;
  logic         overflowed_o;

  slab_res_t pending_hits [$];
  int        mismatches = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        hits_seen = 0;
  int        ovf_seen = 0;
  int        src_idle = 0;   // percent of cycles the sender holds back
  int        snk_idle = 0;   // percent of cycles the receiver stalls

  ray_row_t  steer_rows [15];

  ray_box_slab_intersect dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .box_lo_x_i  (fld[0]),
    .box_lo_y_i  (fld[1]),
    .box_lo_z_i  (fld[2]),
    .box_hi_x_i  (fld[3]),
    .box_hi_y_i  (fld[4]),
    .box_hi_z_i  (fld[5]),
    .origin_x_i  (fld[6]),
    .origin_y_i  (fld[7]),
    .origin_z_i  (fld[8]),
    .dir_x_i     (fld[9]),
    .dir_y_i     (fld[10]),
    .dir_z_i     (fld[11]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .t_near_o    (t_near_o),
    .t_far_o     (t_far_o),
    .overflowed_o(overflowed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < 12; i++) fld[i] = '0;
  end

  // slab distance (plane - origin) / dir, truncated toward zero, saturating
  function automatic longint slab_quot(input longint num, input longint den, inout bit ovf);
    bit          neg;
    logic [63:0] un, ud, lim, q, r, mag;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q   = un / ud;
    r   = un % ud;
    // integer part alone already out of range
    if (q > (lim >> 16)) begin
      ovf = 1'b1;
      return neg ? TNEG : TPOS;
    end
    mag = (q << 16) + ((r << 16) / ud);
    if (mag > lim) begin
      ovf = 1'b1;
      return neg ? TNEG : TPOS;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // latest entry and earliest exit over the three slabs
  function automatic slab_res_t slab_predict(input logic [W-1:0] f [12]);
    longint    tn, tf, lo, hi, o, d, a, b, e, l;
    bit        miss, ovf;
    slab_res_t r;
    tn = TNEG;
    tf = TPOS;
    miss = 1'b0;
    ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo = longint'($signed(f[LO + k]));
      hi = longint'($signed(f[HI + k]));
      o  = longint'($signed(f[ORG + k]));
      d  = longint'($signed(f[DIR + k]));
      if (d == 0) begin
        // parallel to the slab: unbounded if inside, a miss otherwise
        if (lo <= o && o <= hi) begin
          e = TNEG;
          l = TPOS;
        end else begin
          miss = 1'b1;
          e = (o < lo) ? TPOS : TNEG;
          l = e;
        end
      end else begin
        a = slab_quot(lo - o, d, ovf);
        b = slab_quot(hi - o, d, ovf);
        e = (a < b) ? a : b;
        l = (a < b) ? b : a;
      end
      if (e > tn) tn = e;
      if (l < tf) tf = l;
    end
    r.hit    = !miss && (tn <= tf);
    r.t_near = tn[W-1:0];
    r.t_far  = tf[W-1:0];
    r.ovf    = ovf;
    return r;
  endfunction

  task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] want);
    mismatches++;
    $display("mismatch on beat %0d: %s got %h expected %h", beats_out, what, got, want);
  endtask

  // one ray beat: optional idle cycles, then hold until taken
  task automatic send_ray(input logic [W-1:0] f [12], input bit fixed, input slab_res_t res);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    for (int i = 0; i < 12; i++) fld[i] <= f[i];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_hits.push_back(fixed ? res : slab_predict(f));
    beats_in++;
  endtask

  // receiver stalls at random
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= snk_idle);
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    slab_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        $display("mismatch: result beat %0d with nothing outstanding", beats_out);
      end else begin
        want = pending_hits.pop_front();
        if (hit_o !== want.hit) report("hit", W'(hit_o), W'(want.hit));
        if (t_near_o !== want.t_near) report("t_near", t_near_o, want.t_near);
        if (t_far_o !== want.t_far) report("t_far", t_far_o, want.t_far);
        if (overflowed_o !== want.ovf) report("overflowed", W'(overflowed_o), W'(want.ovf));
        if (hit_o === 1'b1) hits_seen++;
        if (overflowed_o === 1'b1) ovf_seen++;
      end
    end
  end

  function automatic logic [W-1:0] near_coord();
    return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
  endfunction

  function automatic logic [W-1:0] odd_coord();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'h1;
      2: return MN;
      3: return MX;
      4: return '1;
      5: return ONE;
      default: return $urandom();
    endcase
  endfunction

  // mostly rays aimed into a sane box, plus awkward values and pure noise
  task automatic random_ray(output logic [W-1:0] f [12]);
    int kind;
    logic [W-1:0] aim;
    kind = $urandom_range(0, 99);
    for (int k = 0; k < 3; k++) begin
      if (kind < 60) begin
        f[LO + k]  = near_coord();
        f[HI + k]  = f[LO + k] + $urandom_range(0, 32'h00ff_ffff);
        f[ORG + k] = near_coord();
        aim = f[LO + k] + ((f[HI + k] - f[LO + k]) >> 1);
        f[DIR + k] = aim - f[ORG + k] + $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
        if ($urandom_range(0, 7) == 0) f[DIR + k] = '0;
        if ($urandom_range(0, 15) == 0) f[DIR + k] = -f[DIR + k];
      end else if (kind < 80) begin
        f[LO + k]  = odd_coord();
        f[HI + k]  = odd_coord();
        f[ORG + k] = odd_coord();
        f[DIR + k] = ($urandom_range(0, 2) == 0) ? '0 : odd_coord();
      end else begin
        f[LO + k]  = $urandom();
        f[HI + k]  = $urandom();
        f[ORG + k] = $urandom();
        f[DIR + k] = $urandom();
      end
    end
  endtask

  initial begin
    // directed rows; fixed results only for the zero direction cases
    steer_rows[0]  = '{'{NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0},
                      1'b1, '{1'b1, MN, MX, 1'b0}};
    // x origin below the slab, parallel ray
    steer_rows[1]  = '{'{NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'hfffe_0000, 0, 0, 0, 0, 0},
                      1'b1, '{1'b0, MX, MX, 1'b0}};
    // x origin above the slab, parallel ray
    steer_rows[2]  = '{'{NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h0002_0000, 0, 0, 0, 0, 0},
                      1'b1, '{1'b0, MN, MN, 1'b0}};
    // origin on the lower or upper plane counts as inside
    steer_rows[3]  = '{'{NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, NEG_ONE, ONE, NEG_ONE, 0, 0, 0},
                      1'b1, '{1'b1, MN, MX, 1'b0}};
    steer_rows[4]  = '{'{32'h0002_0000, NEG_ONE, NEG_ONE, 32'h0004_0000, ONE, ONE, 0, 0, 0,
                        ONE, 0, 0}, 1'b0, '0};
    // tiny direction across the full range saturates
    steer_rows[5]  = '{'{MN, MN, MN, MX, MX, MX, 0, 0, 0, 32'h1, 32'h1, 32'h1}, 1'b0, '0};
    steer_rows[6]  = '{'{MN, MN, MN, MX, MX, MX, MX, MX, MX, MN, MN, MN}, 1'b0, '0};
    steer_rows[7]  = '{'{MN, MN, MN, MX, MX, MX, MN, MN, MN, MX, MX, MX}, 1'b0, '0};
    // inverted box, slanted ray
    steer_rows[8]  = '{'{ONE, ONE, ONE, NEG_ONE, NEG_ONE, NEG_ONE, 32'hfffd_0000, 0, 0,
                        ONE, ONE, ONE}, 1'b0, '0};
    // parallel x with origin below an inverted slab, y and z exit at one
    steer_rows[9]  = '{'{ONE, NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, 0, 0, 0, 0, ONE, ONE},
                      1'b1, '{1'b0, MX, ONE, 1'b0}};
    steer_rows[10] = '{'{MN, MN, MN, MX, MX, MX, MN, MN, MN, '1, '1, '1}, 1'b0, '0};
    steer_rows[11] = '{'{MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b0, '0};
    steer_rows[12] = '{'{MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN}, 1'b0, '0};
    // box behind the ray
    steer_rows[13] = '{'{ONE, ONE, ONE, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0, 0, 0,
                        NEG_ONE, NEG_ONE, NEG_ONE}, 1'b0, '0};
    steer_rows[14] = '{'{NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h0003_0000, 32'h0003_0000,
                        32'h0003_0000, NEG_ONE, NEG_ONE, NEG_ONE}, 1'b0, '0};
  end

  // main sequence
  initial begin
    logic [W-1:0] f [12];
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (steer_rows[i]) send_ray(steer_rows[i].f, steer_rows[i].fixed, steer_rows[i].res);

    // four idling phases, with a full drain between them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 54; snk_idle = 0;  end
        2: begin src_idle = 0;  snk_idle = 54; end
        default: begin src_idle = 26; snk_idle = 26; end
      endcase
      for (int n = 0; n < 310; n++) begin
        random_ray(f);
        send_ray(f, 1'b0, '0);
      end
      // hold the sender until every result is back
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      wait (pending_hits.size() == 0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (60) @(posedge clk_i);

    $display("rays sent %0d, results checked %0d, hits %0d, saturated %0d",
             beats_in, beats_out, hits_seen, ovf_seen);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("ray_box_slab_intersect_test passed");
    end else begin
      $display("ray_box_slab_intersect_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("ray_box_slab_intersect_test failed");
    $finish;
  end

endmodule
